// ===== rtl/swept_capsule_box_collision_test_core_macros.svh =====
// Assertion macros for the swept capsule / box collision core
`ifndef SWEPT_CAPSULE_BOX_COLLISION_TEST_CORE_MACROS_SVH
`define SWEPT_CAPSULE_BOX_COLLISION_TEST_CORE_MACROS_SVH

// same-cycle implication
`define SCBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scbc check failed");

// next-cycle implication
`define SCBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scbc check failed");

`endif

// ===== rtl/scbc_pkg.sv =====
// Shared types, widths and helpers for the swept capsule / box collision core
`timescale 1ns / 1ps
package scbc_pkg;
    localparam int CW  = 16;
    localparam int TFB = 16;
    localparam int PW  = 20;
    localparam int PRW = 40;
    localparam int NW  = 42;
    localparam int DW  = 40;
    localparam int TW  = TFB + 1;
    localparam logic [TW-1:0] T_ONE = TW'(1) << TFB;

    typedef logic signed [PW-1:0] pt_t;
    typedef pt_t [2:0] vec_t;
    typedef logic signed [PRW-1:0] prod_t;
    typedef logic signed [NW-1:0] num_t;
    typedef logic [TW-1:0] tpar_t;

    typedef struct packed {
        logic        mode;
        logic        box_hit;
        vec_t        a;
        vec_t        ab;
        vec_t        lo2;
        vec_t        hi2;
        vec_t        c;
        num_t        len2;
        logic [15:0] rad;
    } ctx_t;

    function automatic pt_t lane_of(input logic [47:0] v, input int k);
        logic signed [CW-1:0] u;
        u = signed'(v[k*CW +: CW]);
        return pt_t'(u);
    endfunction
endpackage

// ===== rtl/scbc_div_pipe.sv =====
// Pipelined restoring divider giving the clamped segment parameter t
`timescale 1ns / 1ps
module scbc_div_pipe (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          in_valid,
    input  scbc_pkg::num_t num,
    input  scbc_pkg::ctx_t ctx_in,
    output logic          out_valid,
    output scbc_pkg::tpar_t t,
    output scbc_pkg::ctx_t ctx_out
);
    import scbc_pkg::*;

    typedef enum logic [1:0] {
        TK_ZERO = 2'd0,
        TK_FULL = 2'd1,
        TK_DIV  = 2'd2
    } tk_t;

    logic [TFB:0]    vld_reg;
    logic [DW-1:0]   r_reg    [0:TFB];
    logic [DW-1:0]   d_reg    [0:TFB];
    logic [TFB-1:0]  q_reg    [0:TFB];
    tk_t             kind_reg [0:TFB];
    ctx_t            ctx_reg  [0:TFB];
    logic [DW-1:0]   rsh      [1:TFB];
    logic [DW-1:0]   r_next   [1:TFB];
    logic [TFB-1:0]  q_next   [1:TFB];
    tk_t             kind_next;

    always_comb
    begin
        if (num <= 0 || ctx_in.len2 == 0)
            kind_next = TK_ZERO;
        else if (num >= ctx_in.len2)
            kind_next = TK_FULL;
        else
            kind_next = TK_DIV;
        for (int i = 1; i <= TFB; i++)
        begin
            rsh[i] = {r_reg[i-1][DW-2:0], 1'b0};
            if (rsh[i] >= d_reg[i-1])
            begin
                r_next[i] = rsh[i] - d_reg[i-1];
                q_next[i] = {q_reg[i-1][TFB-2:0], 1'b1};
            end
            else
            begin
                r_next[i] = rsh[i];
                q_next[i] = {q_reg[i-1][TFB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TFB-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r_reg[0]    <= DW'(num);
            d_reg[0]    <= DW'(ctx_in.len2);
            q_reg[0]    <= '0;
            kind_reg[0] <= kind_next;
            ctx_reg[0]  <= ctx_in;
            for (int i = 1; i <= TFB; i++)
            begin
                r_reg[i]    <= r_next[i];
                d_reg[i]    <= d_reg[i-1];
                q_reg[i]    <= q_next[i];
                kind_reg[i] <= kind_reg[i-1];
                ctx_reg[i]  <= ctx_reg[i-1];
            end
        end
    end

    always_comb
    begin
        case (kind_reg[TFB])
            TK_ZERO: t = '0;
            TK_FULL: t = T_ONE;
            TK_DIV:  t = {1'b0, q_reg[TFB]};
            default: t = '0;
        endcase
    end

    assign out_valid = vld_reg[TFB];
    assign ctx_out   = ctx_reg[TFB];
endmodule

// ===== rtl/swept_capsule_box_collision_test_core.sv =====
// Swept capsule / swept box versus static box collision test, top level
//  channel | direction | handshake                  | payload
//  query   | in        | query_valid / query_stall  | req_type .. box_max
//  result  | out       | result_valid / result_stall| hit
// One item per cycle unless a stalled result holds the pipeline; 47 register
// stages (two 17-stage divider pipelines plus 13 arithmetic stages).
// Reset clears only the valid bits.
// A stalled result freezes the whole pipeline; query_stall follows it.
`timescale 1ns / 1ps
`include "swept_capsule_box_collision_test_core_macros.svh"
module swept_capsule_box_collision_test_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        query_valid,
    output logic        query_stall,
    input  logic        req_type,
    input  logic [47:0] first_corner,
    input  logic [47:0] second_corner,
    input  logic [15:0] capsule_radius,
    input  logic [47:0] movement,
    input  logic [47:0] box_min,
    input  logic [47:0] box_max,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        hit
);
    import scbc_pkg::*;

    logic adv;
    logic [2:0] a_vld_reg;
    logic [4:0] b_vld_reg;
    logic [4:0] c_vld_reg;

    ctx_t ctx1_reg, ctx2_reg, ctx3_reg;
    vec_t ctr1_reg;
    prod_t sq2_reg [3];
    prod_t pr2_reg [3];
    num_t num3_reg;

    logic  d1_vld, d2_vld;
    tpar_t t1, t2;
    ctx_t  d1_ctx, d2_ctx;

    ctx_t  b_ctx_reg [5];
    prod_t bm_reg [3];
    vec_t  bs_reg;
    prod_t bpr_reg [3];
    num_t  bnum_reg;

    ctx_t  c_ctx_reg [4];
    prod_t cm_reg [3];
    vec_t  cs_reg;
    logic signed [PW:0] cd_reg [3];
    logic [2*PW+1:0] csq_reg [3];
    logic [33:0] r2_reg;
    logic hit_reg;

    ctx_t ctx1_next;
    vec_t ctr1_next;
    logic box_next;
    pt_t  p0, p1, lo, hi, mv;
    pt_t  lo_c;
    vec_t c_next;
    ctx_t ctx3_next;
    ctx_t b2_ctx_next;

    assign adv         = !(result_valid && result_stall);
    assign query_stall = !adv;

    always_comb
    begin
        ctx1_next = '0;
        ctr1_next = '0;
        box_next  = 1'b1;
        for (int k = 0; k < 3; k++)
        begin
            mv = lane_of(movement, k);
            p0 = lane_of(first_corner, k) + mv;
            p1 = lane_of(second_corner, k) + mv;
            lo = lane_of(box_min, k);
            hi = lane_of(box_max, k);
            if (!(p0 <= hi && p1 >= lo))
                box_next = 1'b0;
            ctx1_next.a[k]   = p0 <<< 1;
            ctx1_next.ab[k]  = (p1 <<< 1) - (p0 <<< 1);
            ctx1_next.lo2[k] = lo <<< 1;
            ctx1_next.hi2[k] = hi <<< 1;
            ctr1_next[k]     = lo + hi;
        end
        ctx1_next.mode    = req_type;
        ctx1_next.box_hit = box_next;
        ctx1_next.rad     = capsule_radius;
    end

    always_comb
    begin
        ctx3_next      = ctx2_reg;
        ctx3_next.len2 = NW'(sq2_reg[0]) + NW'(sq2_reg[1]) + NW'(sq2_reg[2]);
    end

    always_comb
    begin
        c_next = '0;
        for (int k = 0; k < 3; k++)
        begin
            lo_c = (bs_reg[k] < b_ctx_reg[1].lo2[k]) ? b_ctx_reg[1].lo2[k] : bs_reg[k];
            c_next[k] = (lo_c > b_ctx_reg[1].hi2[k]) ? b_ctx_reg[1].hi2[k] : lo_c;
        end
        b2_ctx_next   = b_ctx_reg[1];
        b2_ctx_next.c = c_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= '0;
            b_vld_reg <= '0;
            c_vld_reg <= '0;
        end
        else if (adv)
        begin
            a_vld_reg <= {a_vld_reg[1:0], query_valid};
            b_vld_reg <= {b_vld_reg[3:0], d1_vld};
            c_vld_reg <= {c_vld_reg[3:0], d2_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx1_reg <= ctx1_next;
            ctr1_reg <= ctr1_next;

            ctx2_reg <= ctx1_reg;
            for (int k = 0; k < 3; k++)
            begin
                sq2_reg[k] <= ctx1_reg.ab[k] * ctx1_reg.ab[k];
                pr2_reg[k] <= (ctr1_reg[k] - ctx1_reg.a[k]) * ctx1_reg.ab[k];
            end

            ctx3_reg <= ctx3_next;
            num3_reg <= NW'(pr2_reg[0]) + NW'(pr2_reg[1]) + NW'(pr2_reg[2]);

            b_ctx_reg[0] <= d1_ctx;
            for (int k = 0; k < 3; k++)
                bm_reg[k] <= $signed({1'b0, t1}) * d1_ctx.ab[k];

            b_ctx_reg[1] <= b_ctx_reg[0];
            for (int k = 0; k < 3; k++)
                bs_reg[k] <= pt_t'(PRW'(b_ctx_reg[0].a[k]) + (bm_reg[k] >>> TFB));

            b_ctx_reg[2] <= b2_ctx_next;

            b_ctx_reg[3] <= b_ctx_reg[2];
            for (int k = 0; k < 3; k++)
                bpr_reg[k] <= (b_ctx_reg[2].c[k] - b_ctx_reg[2].a[k]) * b_ctx_reg[2].ab[k];

            b_ctx_reg[4] <= b_ctx_reg[3];
            bnum_reg     <= NW'(bpr_reg[0]) + NW'(bpr_reg[1]) + NW'(bpr_reg[2]);

            c_ctx_reg[0] <= d2_ctx;
            for (int k = 0; k < 3; k++)
                cm_reg[k] <= $signed({1'b0, t2}) * d2_ctx.ab[k];

            c_ctx_reg[1] <= c_ctx_reg[0];
            for (int k = 0; k < 3; k++)
                cs_reg[k] <= pt_t'(PRW'(c_ctx_reg[0].a[k]) + (cm_reg[k] >>> TFB));

            c_ctx_reg[2] <= c_ctx_reg[1];
            for (int k = 0; k < 3; k++)
                cd_reg[k] <= (PW+1)'(cs_reg[k]) - (PW+1)'(c_ctx_reg[1].c[k]);

            c_ctx_reg[3] <= c_ctx_reg[2];
            for (int k = 0; k < 3; k++)
                csq_reg[k] <= (2*PW+2)'((2*PW+2)'(cd_reg[k]) * (2*PW+2)'(cd_reg[k]));
            r2_reg <= {32'(c_ctx_reg[2].rad) * 32'(c_ctx_reg[2].rad), 2'b00};

            if (c_ctx_reg[3].mode)
                hit_reg <= c_ctx_reg[3].box_hit;
            else
                hit_reg <= (44'(csq_reg[0]) + 44'(csq_reg[1]) + 44'(csq_reg[2]))
                           <= 44'(r2_reg);
        end
    end

    scbc_div_pipe u_div_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (a_vld_reg[2]),
        .num       (num3_reg),
        .ctx_in    (ctx3_reg),
        .out_valid (d1_vld),
        .t         (t1),
        .ctx_out   (d1_ctx)
    );

    scbc_div_pipe u_div_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b_vld_reg[4]),
        .num       (bnum_reg),
        .ctx_in    (b_ctx_reg[4]),
        .out_valid (d2_vld),
        .t         (t2),
        .ctx_out   (d2_ctx)
    );

    assign result_valid = c_vld_reg[4];
    assign hit          = hit_reg;

    `SCBC_ASSERT_NOW(a_t1_range, d1_vld, t1 <= T_ONE)
    `SCBC_ASSERT_NOW(a_t2_range, d2_vld, t2 <= T_ONE)
    `SCBC_ASSERT_NEXT(a_freeze, !adv, $stable(b_vld_reg) && $stable(c_vld_reg))
endmodule
